FILE: src/nn_aspect_fit_scaler_2bpp_unit_assert.svh
// assertion helpers used by the rtl
`ifndef NN_ASPECT_FIT_SCALER_2BPP_UNIT_ASSERT_SVH
`define NN_ASPECT_FIT_SCALER_2BPP_UNIT_ASSERT_SVH

// same-cycle implication
`define NNAFS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nnafs same-cycle check failed");

// next-cycle implication
`define NNAFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nnafs next-cycle check failed");

`endif

FILE: src/nnafs_pkg.sv
package nnafs_pkg;

    localparam int SRC_W_BITS = 13;
    localparam int SRC_H_BITS = 16;
    localparam int SCR_BITS   = 11;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_IDX_BITS = 10;
    localparam int DIVD_BITS  = 27;
    localparam int DIVS_BITS  = 16;
    localparam logic [SCR_BITS-1:0] SCREEN_H_LIMIT = 11'd1024;

    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCR_W = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCR_H = 2'd3;

    typedef enum logic [9:0] {
        ST_IN     = 10'b00_0000_0001,
        ST_FIT    = 10'b00_0000_0010,
        ST_FITW   = 10'b00_0000_0100,
        ST_WRB    = 10'b00_0000_1000,
        ST_PICK   = 10'b00_0001_0000,
        ST_COLDIV = 10'b00_0010_0000,
        ST_RD     = 10'b00_0100_0000,
        ST_ACC    = 10'b00_1000_0000,
        ST_PUSH   = 10'b01_0000_0000,
        ST_ROWEND = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIVD_BITS-1:0] dividend;
        logic [DIVS_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIVD_BITS-1:0] quo;
        logic [DIVS_BITS-1:0] rem;
    } t_div_rsp;

endpackage

FILE: src/nnafs_ram.sv
module nnafs_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  i_waddr,
    input  logic [W-1:0]                          i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  i_raddr,
    output logic [W-1:0]                          o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/nnafs_div.sv
module nnafs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnafs_pkg::t_div_req i_req,
    output nnafs_pkg::t_div_rsp o_rsp
);
    localparam int DW = nnafs_pkg::DIVD_BITS;
    localparam int SW = nnafs_pkg::DIVS_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [SW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_div;
    logic [SW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem[SW-1:0], r_quo[DW-1]};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_div}) : w_sh;
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[SW-1:0];
endmodule

FILE: src/nn_aspect_fit_scaler_2bpp_unit.sv
// aspect-fit nearest-neighbor downscaler for 2-bit-per-pixel images
// input stream: tdata carries one packed source byte (four pixels, leftmost in
// bits 7:6), tuser marks the first byte of an image. output stream: tdata is a
// 32-bit word of 16 pixels, tlast ends an output row, tuser carries the end of
// image flag and the output row index.
// bytes inside a row are taken one per cycle. unless the sizes fit the screen
// or one is zero, the first byte of an image runs a fit division in the
// shared divider before it is stored. while output rows remain, the last byte
// of a row runs a division for the row pick; a picked row then runs a column
// step division and reads the line store one pixel at a time through the read
// and accumulate states (single read port plus registered read), then a push
// state per output word; the next byte is taken only after the row is done.
// the output word sits in a register: the block moves on while it waits, and a
// stalled receiver only holds the next word back.
// reset sets all size registers to 1, clears the counters and leaves the block
// idle until a request with start of image; no clearing pass of the line store.
module nn_aspect_fit_scaler_2bpp_unit #(
    parameter int MAX_SOURCE_WIDTH = 4096,
    parameter int MAX_SCREEN_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // packed_byte
    input  logic [0:0]  i_s_tuser,   // start_of_image
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // pixel_word
    output logic        o_m_tlast,
    output logic [10:0] o_m_tuser,   // out_row_index[9:0], last_in_image
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    `include "nn_aspect_fit_scaler_2bpp_unit_assert.svh"

    localparam int LINE_BYTES = (MAX_SOURCE_WIDTH + 3) / 4;
    localparam int ADDRW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int BCW = $clog2(LINE_BYTES + 1);
    localparam int MSWV = (MAX_SOURCE_WIDTH > 8191) ? 8191 : MAX_SOURCE_WIDTH;
    localparam logic [12:0] MAX_SW = 13'(MSWV);
    localparam logic [10:0] MAX_CW = 11'(MAX_SCREEN_WIDTH);

    nnafs_pkg::t_state  r_state;
    nnafs_pkg::t_div_req w_req;
    nnafs_pkg::t_div_rsp w_rsp;

    logic [12:0] r_src_w;
    logic [15:0] r_src_h;
    logic [10:0] r_scr_w;
    logic [10:0] r_scr_h;

    logic [BCW-1:0] r_bc;
    logic [15:0]    r_src_cnt;
    logic [10:0]    r_orc;
    logic [10:0]    r_fit_w;
    logic [10:0]    r_fit_h;
    logic           r_done;
    logic           r_selw;
    logic [7:0]     r_byte;

    logic [12:0] r_q0;
    logic [10:0] r_r0;
    logic [12:0] r_sx;
    logic [10:0] r_racc;
    logic [10:0] r_x;
    logic [3:0]  r_p;
    logic [1:0]  r_sxl;
    logic [31:0] r_word;
    logic        r_lastpx;

    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_lir;
    logic        r_out_lim;
    logic [9:0]  r_out_idx;

    logic [12:0] w_sw;
    logic [10:0] w_cw;
    logic [10:0] w_ch;
    logic        w_zero;
    logic        w_fits;
    logic [26:0] w_wp;
    logic [26:0] w_hp;
    logic        w_selw;
    logic [15:0] w_val;
    logic [15:0] w_ow;
    logic [15:0] w_oh;
    logic        w_accept;
    logic        w_wr;
    logic [7:0]  w_wbyte;
    logic [BCW-1:0] w_bc1;
    logic [15:0] w_rb;
    logic        w_row_end;
    logic [26:0] w_orc_sh;
    logic [ADDRW+12:0] w_sx_sh;
    logic [ADDRW-1:0] w_raddr;
    logic [7:0]  w_rdata;
    logic [1:0]  w_pix;
    logic [11:0] w_sum;
    logic        w_load;
    logic [16:0] w_sc1;

    assign w_sw   = (r_src_w > MAX_SW) ? MAX_SW : r_src_w;
    assign w_cw   = (r_scr_w > MAX_CW) ? MAX_CW : r_scr_w;
    assign w_ch   = (r_scr_h > nnafs_pkg::SCREEN_H_LIMIT) ? nnafs_pkg::SCREEN_H_LIMIT : r_scr_h;
    assign w_zero = (w_sw == '0) || (r_src_h == '0) || (w_cw == '0) || (w_ch == '0);
    assign w_fits = (16'(w_sw) <= 16'(w_cw)) && (r_src_h <= 16'(w_ch));
    assign w_wp   = 27'(w_cw) * 27'(r_src_h);
    assign w_hp   = 27'(w_ch) * 27'(w_sw);
    assign w_selw = w_wp <= w_hp;

    assign w_val = (w_rsp.quo == '0) ? 16'd1 :
                   ((w_rsp.quo > 27'hFFFF) ? 16'hFFFF : w_rsp.quo[15:0]);
    assign w_ow  = r_selw ? 16'(w_cw) : w_val;
    assign w_oh  = r_selw ? w_val : 16'(w_ch);

    assign o_s_tready = (r_state == nnafs_pkg::ST_IN);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_wr       = (w_accept && !i_s_tuser[0] && !r_done) || (r_state == nnafs_pkg::ST_WRB);
    assign w_wbyte    = (r_state == nnafs_pkg::ST_WRB) ? r_byte : i_s_tdata;
    assign w_bc1      = r_bc + 1'b1;
    assign w_rb       = (16'(w_sw) + 16'd3) >> 2;
    assign w_row_end  = 16'(w_bc1) >= w_rb;
    assign w_orc_sh   = 27'(r_orc) * 27'(r_src_h);

    assign w_sx_sh = {{ADDRW{1'b0}}, r_sx} >> 2;
    assign w_raddr = w_sx_sh[ADDRW-1:0];
    assign w_pix   = w_rdata[{~r_sxl, 1'b0} +: 2];
    assign w_sum   = 12'(r_racc) + 12'(r_r0);
    assign w_load  = (r_state == nnafs_pkg::ST_PUSH) && (!r_out_valid || i_m_tready);
    assign w_sc1   = 17'(r_src_cnt) + 17'd1;

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = w_selw ? w_wp : w_hp;
        w_req.divisor  = w_selw ? 16'(w_sw) : r_src_h;
        unique case (r_state)
            nnafs_pkg::ST_FIT: begin
                w_req.start = !w_zero && !w_fits;
            end
            nnafs_pkg::ST_IN, nnafs_pkg::ST_WRB: begin
                w_req.start    = w_wr && w_row_end && (r_orc < r_fit_h);
                w_req.dividend = w_orc_sh;
                w_req.divisor  = 16'(r_fit_h);
            end
            nnafs_pkg::ST_PICK: begin
                w_req.start    = w_rsp.done && (w_rsp.quo == 27'(r_src_cnt));
                w_req.dividend = 27'(w_sw);
                w_req.divisor  = 16'(r_fit_w);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    nnafs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    nnafs_ram #(
        .W(8),
        .D(LINE_BYTES)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (w_wr),
        .i_waddr(r_bc[ADDRW-1:0]),
        .i_wdata(w_wbyte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 13'd1;
            r_src_h <= 16'd1;
            r_scr_w <= 11'd1;
            r_scr_h <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nnafs_pkg::REG_SRC_W: r_src_w <= i_cfg_data[12:0];
                nnafs_pkg::REG_SRC_H: r_src_h <= i_cfg_data;
                nnafs_pkg::REG_SCR_W: r_scr_w <= i_cfg_data[10:0];
                nnafs_pkg::REG_SCR_H: r_scr_h <= i_cfg_data[10:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nnafs_pkg::ST_IN;
            r_bc        <= '0;
            r_src_cnt   <= '0;
            r_orc       <= '0;
            r_fit_w     <= '0;
            r_fit_h     <= '0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr) begin
                r_bc <= w_row_end ? '0 : w_bc1;
            end
            unique case (r_state)
                nnafs_pkg::ST_IN, nnafs_pkg::ST_WRB: begin
                    if (w_accept && i_s_tuser[0]) begin
                        r_state <= nnafs_pkg::ST_FIT;
                    end else if (w_wr) begin
                        if (!w_row_end) begin
                            r_state <= nnafs_pkg::ST_IN;
                        end else if (r_orc < r_fit_h) begin
                            r_state <= nnafs_pkg::ST_PICK;
                        end else begin
                            r_state <= nnafs_pkg::ST_ROWEND;
                        end
                    end
                end
                nnafs_pkg::ST_FIT: begin
                    r_bc      <= '0;
                    r_src_cnt <= '0;
                    r_orc     <= '0;
                    if (w_zero) begin
                        r_done  <= 1'b1;
                        r_state <= nnafs_pkg::ST_IN;
                    end else if (w_fits) begin
                        r_fit_w <= w_sw[10:0];
                        r_fit_h <= r_src_h[10:0];
                        r_done  <= 1'b0;
                        r_state <= nnafs_pkg::ST_WRB;
                    end else begin
                        r_state <= nnafs_pkg::ST_FITW;
                    end
                end
                nnafs_pkg::ST_FITW: begin
                    if (w_rsp.done) begin
                        if ((w_ow > 16'(w_cw)) || (w_oh > 16'(w_ch))) begin
                            r_done  <= 1'b1;
                            r_state <= nnafs_pkg::ST_IN;
                        end else begin
                            r_fit_w <= w_ow[10:0];
                            r_fit_h <= w_oh[10:0];
                            r_done  <= 1'b0;
                            r_state <= nnafs_pkg::ST_WRB;
                        end
                    end
                end
                nnafs_pkg::ST_PICK: begin
                    if (w_rsp.done) begin
                        r_state <= (w_rsp.quo == 27'(r_src_cnt)) ? nnafs_pkg::ST_COLDIV
                                                                  : nnafs_pkg::ST_ROWEND;
                    end
                end
                nnafs_pkg::ST_COLDIV: begin
                    if (w_rsp.done) begin
                        r_state <= nnafs_pkg::ST_RD;
                    end
                end
                nnafs_pkg::ST_RD: begin
                    r_state <= nnafs_pkg::ST_ACC;
                end
                nnafs_pkg::ST_ACC: begin
                    r_state <= ((r_x + 11'd1 == r_fit_w) || (r_p == 4'hF)) ? nnafs_pkg::ST_PUSH
                                                                          : nnafs_pkg::ST_RD;
                end
                nnafs_pkg::ST_PUSH: begin
                    if (w_load) begin
                        if (r_lastpx) begin
                            r_orc   <= r_orc + 11'd1;
                            r_state <= nnafs_pkg::ST_ROWEND;
                        end else begin
                            r_state <= nnafs_pkg::ST_RD;
                        end
                    end
                end
                nnafs_pkg::ST_ROWEND: begin
                    r_src_cnt <= w_sc1[15:0];
                    if (w_sc1 >= 17'(r_src_h)) begin
                        r_done <= 1'b1;
                    end
                    r_state <= nnafs_pkg::ST_IN;
                end
                default: begin
                    r_state <= nnafs_pkg::ST_IN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_s_tdata;
        end
        if (r_state == nnafs_pkg::ST_FIT) begin
            r_selw <= w_selw;
        end
        if ((r_state == nnafs_pkg::ST_COLDIV) && w_rsp.done) begin
            r_q0   <= w_rsp.quo[12:0];
            r_r0   <= w_rsp.rem[10:0];
            r_sx   <= '0;
            r_racc <= '0;
            r_x    <= '0;
            r_p    <= '0;
            r_word <= '0;
        end
        if (r_state == nnafs_pkg::ST_RD) begin
            r_sxl <= r_sx[1:0];
        end
        if (r_state == nnafs_pkg::ST_ACC) begin
            r_word[{~r_p, 1'b0} +: 2] <= w_pix;
            r_lastpx <= (r_x + 11'd1 == r_fit_w);
            r_x      <= r_x + 11'd1;
            r_p      <= r_p + 4'd1;
            if (w_sum >= 12'(r_fit_w)) begin
                r_racc <= 11'(w_sum - 12'(r_fit_w));
                r_sx   <= r_sx + r_q0 + 13'd1;
            end else begin
                r_racc <= w_sum[10:0];
                r_sx   <= r_sx + r_q0;
            end
        end
        if (w_load) begin
            r_out_data <= r_word;
            r_out_lir  <= r_lastpx;
            r_out_lim  <= r_lastpx && (r_orc + 11'd1 == r_fit_h);
            r_out_idx  <= r_orc[9:0];
            r_p        <= '0;
            r_word     <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_lir;
    assign o_m_tuser  = {r_out_idx, r_out_lim};

    `NNAFS_ASSERT_NEXT(a_out_hold, r_out_valid && !i_m_tready, r_out_valid)
    `NNAFS_ASSERT_IMPL(a_wr_state, w_wr,
        (r_state == nnafs_pkg::ST_IN) || (r_state == nnafs_pkg::ST_WRB))
    `NNAFS_ASSERT_IMPL(a_x_range, r_state == nnafs_pkg::ST_RD, r_x < r_fit_w)
    `NNAFS_ASSERT_IMPL(a_lim_lir, r_out_valid && r_out_lim, r_out_lir)
endmodule
